[design/lbmc_pkg.sv]
// Shared types, constants and saturating arithmetic helpers for the D2Q9 collision block.
package lbmc_pkg;

    localparam int DATA_WIDTH = 48;
    localparam int FRAC_BITS  = 40;
    localparam int NDIR       = 9;
    localparam int COEF_BITS  = 18;
    localparam int COEF_SHIFT = 16;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [COEF_BITS-1:0] coef_t;
    typedef data_t [NDIR-1:0] dirs_t;

    typedef enum logic [1:0] {
        CFG_RELAX_INV_TAU = 2'd0,
        CFG_FORCE_WEIGHT  = 2'd1,
        CFG_BODY_ACCEL    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        data_t f_rest;
        data_t f_east;
        data_t f_north;
        data_t f_west;
        data_t f_south;
        data_t f_northeast;
        data_t f_northwest;
        data_t f_southwest;
        data_t f_southeast;
        data_t force_x;
        data_t force_y;
        logic  is_solid;
    } item_t;

    typedef struct packed {
        data_t out_rest;
        data_t out_east;
        data_t out_north;
        data_t out_west;
        data_t out_south;
        data_t out_northeast;
        data_t out_northwest;
        data_t out_southwest;
        data_t out_southeast;
        data_t density;
        data_t vel_x;
        data_t vel_y;
    } result_t;

    localparam logic [63:0] DMAX_U = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
    localparam data_t DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    localparam int DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    localparam int SWAP_DIR [NDIR] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};

    function automatic data_t from_u(logic [63:0] m);
        return (m > DMAX_U) ? DMAX : data_t'(m[DATA_WIDTH-1:0]);
    endfunction

    localparam logic [63:0] W_REST_U = ((64'd4 << FRAC_BITS) + 64'd4) / 64'd9;
    localparam logic [63:0] W_AXIS_U = ((64'd1 << FRAC_BITS) + 64'd4) / 64'd9;
    localparam logic [63:0] W_DIAG_U = ((64'd1 << FRAC_BITS) + 64'd18) / 64'd36;
    localparam data_t WEIGHT [NDIR] = '{
        from_u(W_REST_U), from_u(W_AXIS_U), from_u(W_AXIS_U), from_u(W_AXIS_U),
        from_u(W_AXIS_U), from_u(W_DIAG_U), from_u(W_DIAG_U), from_u(W_DIAG_U),
        from_u(W_DIAG_U)
    };

    localparam data_t ONE = from_u(64'd1 << FRAC_BITS);
    localparam logic [63:0] RMIN_U =
        ((64'd1 << FRAC_BITS) + 64'd500000000000) / 64'd1000000000000;
    localparam data_t RMIN = (RMIN_U == 64'd0) ? data_t'(1) : from_u(RMIN_U);

    function automatic data_t sadd(data_t a, data_t b);
        logic [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
            return s[DATA_WIDTH] ? DMIN : DMAX;
        return data_t'(s[DATA_WIDTH-1:0]);
    endfunction

    function automatic data_t ssub(data_t a, data_t b);
        logic [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
            return s[DATA_WIDTH] ? DMIN : DMAX;
        return data_t'(s[DATA_WIDTH-1:0]);
    endfunction

    function automatic data_t sdir(int e, data_t a);
        if (e > 0)
            return a;
        if (e < 0)
            return ssub('0, a);
        return '0;
    endfunction

    // Product with a small positive constant, then a right shift of zero or one bit,
    // rounded half away from zero and saturated.
    function automatic data_t mul_small(data_t a, int c, int sh);
        logic [DATA_WIDTH-1:0] ma;
        logic [DATA_WIDTH+4:0] m;
        logic [DATA_WIDTH+4:0] lim;
        ma = a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : DATA_WIDTH'(a);
        m = (DATA_WIDTH+5)'(ma) * (DATA_WIDTH+5)'(c);
        m = (m + (((DATA_WIDTH+5)'(1) << sh) >> 1)) >> sh;
        lim = (DATA_WIDTH+5)'(DMAX_U) + (DATA_WIDTH+5)'(a[DATA_WIDTH-1]);
        if (m > lim)
            m = lim;
        return a[DATA_WIDTH-1] ? data_t'(-m[DATA_WIDTH-1:0]) : data_t'(m[DATA_WIDTH-1:0]);
    endfunction

    function automatic dirs_t item_dirs(item_t it);
        dirs_t d;
        d[0] = it.f_rest;
        d[1] = it.f_east;
        d[2] = it.f_north;
        d[3] = it.f_west;
        d[4] = it.f_south;
        d[5] = it.f_northeast;
        d[6] = it.f_northwest;
        d[7] = it.f_southwest;
        d[8] = it.f_southeast;
        return d;
    endfunction

    function automatic result_t pack_result(dirs_t d, data_t rho, data_t u, data_t v);
        result_t r;
        r.out_rest      = d[0];
        r.out_east      = d[1];
        r.out_north     = d[2];
        r.out_west      = d[3];
        r.out_south     = d[4];
        r.out_northeast = d[5];
        r.out_northwest = d[6];
        r.out_southwest = d[7];
        r.out_southeast = d[8];
        r.density       = rho;
        r.vel_x         = u;
        r.vel_y         = v;
        return r;
    endfunction

endpackage

[design/lbmc_mul.sv]
// Two-stage signed fixed-point multiplier built from four half-width partial products.
module lbmc_mul #(
    parameter int SHIFT = 40
) (
    input  logic           clk,
    input  lbmc_pkg::data_t a,
    input  lbmc_pkg::data_t b,
    output lbmc_pkg::data_t p
);
    import lbmc_pkg::*;

    localparam int HL = (DATA_WIDTH + 1) / 2;
    localparam int HH = DATA_WIDTH - HL;
    localparam int PW = 2 * DATA_WIDTH;
    localparam logic [PW-1:0] RND = ((PW)'(1) << SHIFT) >> 1;

    logic [DATA_WIDTH-1:0] ma;
    logic [DATA_WIDTH-1:0] mb;
    logic [2*HL-1:0]       ll_reg;
    logic [HL+HH-1:0]      lh_reg;
    logic [HL+HH-1:0]      hl_reg;
    logic [2*HH-1:0]       hh_reg;
    logic                  neg_reg;
    logic [PW-1:0]         sum;
    logic [PW-1:0]         shifted;
    logic [PW-1:0]         lim;
    logic [PW-1:0]         mag;
    data_t                 p_reg;

    always_comb
    begin
        ma = a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : DATA_WIDTH'(a);
        mb = b[DATA_WIDTH-1] ? DATA_WIDTH'(-b) : DATA_WIDTH'(b);
    end

    always_ff @(posedge clk)
    begin
        ll_reg  <= ma[HL-1:0] * mb[HL-1:0];
        lh_reg  <= ma[HL-1:0] * mb[DATA_WIDTH-1:HL];
        hl_reg  <= ma[DATA_WIDTH-1:HL] * mb[HL-1:0];
        hh_reg  <= ma[DATA_WIDTH-1:HL] * mb[DATA_WIDTH-1:HL];
        neg_reg <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
    end

    // Rounding works on the magnitude, so ties go away from zero.
    always_comb
    begin
        sum = PW'(ll_reg) + (PW'(lh_reg) << HL) + (PW'(hl_reg) << HL)
            + (PW'(hh_reg) << (2 * HL));
        shifted = (sum + RND) >> SHIFT;
        lim = PW'(DMAX_U) + PW'(neg_reg);
        mag = (shifted > lim) ? lim : shifted;
    end

    always_ff @(posedge clk)
    begin
        p_reg <= neg_reg ? data_t'(-mag[DATA_WIDTH-1:0]) : data_t'(mag[DATA_WIDTH-1:0]);
    end

    assign p = p_reg;

endmodule

[design/lbmc_div.sv]
// Pipelined restoring divider: round(num * 2^FRAC_BITS / den), one quotient bit per stage.
module lbmc_div (
    input  logic           clk,
    input  lbmc_pkg::data_t num,
    input  lbmc_pkg::data_t den,
    output lbmc_pkg::data_t quo
);
    import lbmc_pkg::*;

    localparam int NumW  = DATA_WIDTH + FRAC_BITS;
    localparam int Steps = DATA_WIDTH;

    logic [DATA_WIDTH-1:0] rem_reg  [0:Steps];
    logic [DATA_WIDTH-1:0] q_reg    [0:Steps];
    logic [DATA_WIDTH-1:0] bits_reg [0:Steps];
    logic [DATA_WIDTH-1:0] den_reg  [0:Steps];
    logic                  neg_reg  [0:Steps];
    logic                  ovf_reg  [0:Steps];
    logic [DATA_WIDTH-1:0] shifted  [1:Steps];
    logic [DATA_WIDTH-1:0] rem_next [1:Steps];
    logic [DATA_WIDTH-1:0] q_next   [1:Steps];

    logic [DATA_WIDTH-1:0] mag_num;
    logic [DATA_WIDTH-1:0] den_u;
    logic [NumW-1:0]       num_full;
    logic [FRAC_BITS-1:0]  num_hi;
    logic                  ovf;
    logic                  inc;
    logic [DATA_WIDTH:0]   q_round;
    logic [DATA_WIDTH:0]   lim;
    logic [DATA_WIDTH:0]   mag;
    data_t                 quo_reg;

    // The quotient overflows the word when the upper numerator part already
    // reaches the divisor; the remaining bits then go through the stages.
    always_comb
    begin
        mag_num  = num[DATA_WIDTH-1] ? DATA_WIDTH'(-num) : DATA_WIDTH'(num);
        den_u    = den;
        num_full = NumW'(mag_num) << FRAC_BITS;
        num_hi   = num_full[NumW-1:DATA_WIDTH];
        ovf      = NumW'(num_hi) >= NumW'(den_u);
        for (int i = 1; i <= Steps; i++)
        begin
            shifted[i] = {rem_reg[i-1][DATA_WIDTH-2:0], bits_reg[i-1][DATA_WIDTH-1]};
            if (shifted[i] >= den_reg[i-1])
            begin
                rem_next[i] = shifted[i] - den_reg[i-1];
                q_next[i]   = {q_reg[i-1][DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = shifted[i];
                q_next[i]   = {q_reg[i-1][DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= DATA_WIDTH'(num_hi);
        q_reg[0]    <= '0;
        bits_reg[0] <= num_full[DATA_WIDTH-1:0];
        den_reg[0]  <= den_u;
        neg_reg[0]  <= num[DATA_WIDTH-1];
        ovf_reg[0]  <= ovf;
        for (int i = 1; i <= Steps; i++)
        begin
            rem_reg[i]  <= rem_next[i];
            q_reg[i]    <= q_next[i];
            bits_reg[i] <= bits_reg[i-1] << 1;
            den_reg[i]  <= den_reg[i-1];
            neg_reg[i]  <= neg_reg[i-1];
            ovf_reg[i]  <= ovf_reg[i-1];
        end
    end

    always_comb
    begin
        inc     = rem_reg[Steps] >= (den_reg[Steps] - rem_reg[Steps]);
        q_round = {1'b0, q_reg[Steps]} + (DATA_WIDTH+1)'(inc);
        lim     = {1'b0, DMAX_U[DATA_WIDTH-1:0]} + (DATA_WIDTH+1)'(neg_reg[Steps]);
        mag     = (ovf_reg[Steps] || q_round > lim) ? lim : q_round;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= neg_reg[Steps] ? data_t'(-mag[DATA_WIDTH-1:0])
                                  : data_t'(mag[DATA_WIDTH-1:0]);
    end

    assign quo = quo_reg;

endmodule

[design/lbmc_dir.sv]
// Collision datapath for one lattice direction: equilibrium, Guo source and relaxation.
module lbmc_dir #(
    parameter int K = 0
) (
    input  logic            clk,
    input  lbmc_pkg::data_t u,
    input  lbmc_pkg::data_t v,
    input  lbmc_pkg::data_t fx,
    input  lbmc_pkg::data_t fy,
    input  lbmc_pkg::data_t rho,
    input  lbmc_pkg::data_t f,
    input  lbmc_pkg::data_t h3uu,
    input  lbmc_pkg::coef_t relax_inv_tau,
    input  lbmc_pkg::coef_t force_weight,
    output lbmc_pkg::data_t res
);
    import lbmc_pkg::*;

    localparam int EX = DIR_X[K];
    localparam int EY = DIR_Y[K];
    localparam data_t W = WEIGHT[K];

    data_t fd_reg [1:10];
    data_t eu1_reg, ef1_reg, a1_reg, a2_reg, fx1_reg, fy1_reg, rho1_reg;
    data_t eu2_reg, eu3_reg;
    data_t eueu, wrho, ta, tb, euef;
    data_t poly1_reg, t1s_reg, n9_reg, wrho4_reg;
    data_t poly_reg, s_reg, wrho5_reg;
    data_t feq, ws, src, rel;
    data_t diff_reg, src10_reg, o_reg, src11_reg;
    data_t tau_coef, fw_coef;

    assign tau_coef = data_t'(relax_inv_tau);
    assign fw_coef  = data_t'(force_weight);

    always_ff @(posedge clk)
    begin
        fd_reg[1] <= f;
        for (int i = 2; i <= 10; i++)
            fd_reg[i] <= fd_reg[i-1];
        eu1_reg   <= sadd(sdir(EX, u), sdir(EY, v));
        ef1_reg   <= sadd(sdir(EX, fx), sdir(EY, fy));
        a1_reg    <= ssub(sdir(EX, ONE), u);
        a2_reg    <= ssub(sdir(EY, ONE), v);
        fx1_reg   <= fx;
        fy1_reg   <= fy;
        rho1_reg  <= rho;
        eu2_reg   <= eu1_reg;
        eu3_reg   <= eu2_reg;
        poly1_reg <= sadd(sadd(ONE, mul_small(eu3_reg, 3, 0)), mul_small(eueu, 9, 1));
        t1s_reg   <= sadd(ta, tb);
        n9_reg    <= mul_small(euef, 9, 0);
        wrho4_reg <= wrho;
        poly_reg  <= ssub(poly1_reg, h3uu);
        s_reg     <= sadd(mul_small(t1s_reg, 3, 0), n9_reg);
        wrho5_reg <= wrho4_reg;
        diff_reg  <= ssub(fd_reg[7], feq);
        src10_reg <= src;
        o_reg     <= ssub(fd_reg[10], rel);
        src11_reg <= src10_reg;
    end

    lbmc_mul #(.SHIFT(FRAC_BITS)) u_eueu (.clk(clk), .a(eu1_reg), .b(eu1_reg), .p(eueu));
    lbmc_mul #(.SHIFT(FRAC_BITS)) u_wrho (.clk(clk), .a(W), .b(rho1_reg), .p(wrho));
    lbmc_mul #(.SHIFT(FRAC_BITS)) u_ta (.clk(clk), .a(a1_reg), .b(fx1_reg), .p(ta));
    lbmc_mul #(.SHIFT(FRAC_BITS)) u_tb (.clk(clk), .a(a2_reg), .b(fy1_reg), .p(tb));
    lbmc_mul #(.SHIFT(FRAC_BITS)) u_euef (.clk(clk), .a(eu1_reg), .b(ef1_reg), .p(euef));
    lbmc_mul #(.SHIFT(FRAC_BITS)) u_feq (.clk(clk), .a(wrho5_reg), .b(poly_reg), .p(feq));
    lbmc_mul #(.SHIFT(FRAC_BITS)) u_ws (.clk(clk), .a(W), .b(s_reg), .p(ws));
    lbmc_mul #(.SHIFT(COEF_SHIFT)) u_src (.clk(clk), .a(ws), .b(fw_coef), .p(src));
    lbmc_mul #(.SHIFT(COEF_SHIFT)) u_rel (.clk(clk), .a(diff_reg), .b(tau_coef), .p(rel));

    assign res = sadd(o_reg, src11_reg);

endmodule

[design/lbm_d2q9_bgk_collision.sv]
// D2Q9 BGK collision with Guo forcing: top level with moments, divider and output stage.
//
// Usage: one lattice cell is transferred on the item port at a rising edge where
// start is high and busy is low. busy never rises, so a cell can be transferred on
// every clock. Each cell gives exactly one result on the result port, marked by
// result_valid for one cycle, in order. The depth is set by the moment sums (four
// stages), the velocity divider (one quotient bit per stage, DATA_WIDTH + 2 stages)
// and the per-direction collision datapath (pipelined multipliers and saturating
// adds). Throughput is one cell per clock.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while no cell is in flight. An unknown index is ignored.
// Reset clears the pipeline valid bits and loads the default coefficients; results
// cannot be held off by the receiver, so nothing in the block ever stalls.
module lbm_d2q9_bgk_collision (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  lbmc_pkg::item_t      item,
    output logic                 result_valid,
    output lbmc_pkg::result_t    result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  lbmc_pkg::cfg_index_t cfg_index,
    input  lbmc_pkg::data_t      cfg_data
);
    import lbmc_pkg::*;

    localparam int DivLat = DATA_WIDTH + 2;
    localparam int DirLat = 11;
    localparam int Total  = 6 + DivLat + DirLat;

    typedef struct packed {
        dirs_t f;
        data_t fx;
        data_t fy;
        data_t rho;
        logic  solid;
    } side_t;

    typedef struct packed {
        dirs_t fswap;
        data_t rho;
        data_t u;
        data_t v;
        logic  solid;
    } tail_t;

    coef_t relax_reg;
    coef_t fweight_reg;
    data_t accel_reg;
    logic [Total-1:0] vld_reg;

    item_t item_reg;
    dirs_t m_f_reg   [1:4];
    data_t m_fx_reg  [1:4];
    data_t m_fy_reg  [1:4];
    logic  m_solid_reg [1:4];
    data_t m_rho_reg [1:3];
    data_t m_mx_reg  [1:3];
    data_t m_my_reg  [1:3];
    data_t rho4_reg, nx_reg, ny_reg;

    dirs_t mf      [0:2];
    data_t acc_rho [0:2];
    data_t acc_mx  [0:2];
    data_t acc_my  [0:2];
    data_t nxt_rho [0:2];
    data_t nxt_mx  [0:2];
    data_t nxt_my  [0:2];

    side_t side_reg [0:DivLat-1];
    tail_t tail_reg [0:DirLat-1];
    side_t side0;
    tail_t tail_next;
    data_t u0, v0, uu_u, uu_v, uu3_reg, h3uu_reg;
    dirs_t fluid;
    dirs_t fswap;
    result_t result_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relax_reg   <= coef_t'(81920);
            fweight_reg <= coef_t'(24576);
            accel_reg   <= data_t'(26146);
            vld_reg     <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[Total-2:0], start && !busy};
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_RELAX_INV_TAU: relax_reg   <= cfg_data[COEF_BITS-1:0];
                    CFG_FORCE_WEIGHT:  fweight_reg <= cfg_data[COEF_BITS-1:0];
                    CFG_BODY_ACCEL:    accel_reg   <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    // Moment sums keep the saturating order of the directions: three per stage.
    always_comb
    begin
        mf[0] = item_dirs(item_reg);
        mf[1] = m_f_reg[1];
        mf[2] = m_f_reg[2];
        acc_rho[0] = '0;
        acc_mx[0]  = '0;
        acc_my[0]  = '0;
        for (int s = 1; s < 3; s++)
        begin
            acc_rho[s] = m_rho_reg[s];
            acc_mx[s]  = m_mx_reg[s];
            acc_my[s]  = m_my_reg[s];
        end
        for (int s = 0; s < 3; s++)
        begin
            nxt_rho[s] = acc_rho[s];
            nxt_mx[s]  = acc_mx[s];
            nxt_my[s]  = acc_my[s];
            for (int j = 0; j < 3; j++)
            begin
                nxt_rho[s] = sadd(nxt_rho[s], mf[s][3*s+j]);
                nxt_mx[s]  = sadd(nxt_mx[s], sdir(DIR_X[3*s+j], mf[s][3*s+j]));
                nxt_my[s]  = sadd(nxt_my[s], sdir(DIR_Y[3*s+j], mf[s][3*s+j]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item;
        m_f_reg[1]     <= item_dirs(item_reg);
        m_fx_reg[1]    <= sadd(item_reg.force_x, accel_reg);
        m_fy_reg[1]    <= item_reg.force_y;
        m_solid_reg[1] <= item_reg.is_solid;
        for (int s = 2; s <= 4; s++)
        begin
            m_f_reg[s]     <= m_f_reg[s-1];
            m_fx_reg[s]    <= m_fx_reg[s-1];
            m_fy_reg[s]    <= m_fy_reg[s-1];
            m_solid_reg[s] <= m_solid_reg[s-1];
        end
        for (int s = 1; s <= 3; s++)
        begin
            m_rho_reg[s] <= nxt_rho[s-1];
            m_mx_reg[s]  <= nxt_mx[s-1];
            m_my_reg[s]  <= nxt_my[s-1];
        end
        rho4_reg <= (m_rho_reg[3] < RMIN) ? RMIN : m_rho_reg[3];
        nx_reg   <= sadd(m_mx_reg[3], mul_small(m_fx_reg[3], 1, 1));
        ny_reg   <= sadd(m_my_reg[3], mul_small(m_fy_reg[3], 1, 1));
    end

    lbmc_div u_div_x (.clk(clk), .num(nx_reg), .den(rho4_reg), .quo(u0));
    lbmc_div u_div_y (.clk(clk), .num(ny_reg), .den(rho4_reg), .quo(v0));

    always_ff @(posedge clk)
    begin
        side_reg[0] <= '{f: m_f_reg[4], fx: m_fx_reg[4], fy: m_fy_reg[4],
                         rho: rho4_reg, solid: m_solid_reg[4]};
        for (int i = 1; i < DivLat; i++)
            side_reg[i] <= side_reg[i-1];
    end

    assign side0 = side_reg[DivLat-1];

    lbmc_mul #(.SHIFT(FRAC_BITS)) u_uu_u (.clk(clk), .a(u0), .b(u0), .p(uu_u));
    lbmc_mul #(.SHIFT(FRAC_BITS)) u_uu_v (.clk(clk), .a(v0), .b(v0), .p(uu_v));

    always_ff @(posedge clk)
    begin
        uu3_reg  <= sadd(uu_u, uu_v);
        h3uu_reg <= mul_small(uu3_reg, 3, 1);
    end

    genvar k;
    generate
        for (k = 0; k < NDIR; k++)
        begin : g_dir
            lbmc_dir #(.K(k)) u_dir (
                .clk           (clk),
                .u             (u0),
                .v             (v0),
                .fx            (side0.fx),
                .fy            (side0.fy),
                .rho           (side0.rho),
                .f             (side0.f[k]),
                .h3uu          (h3uu_reg),
                .relax_inv_tau (relax_reg),
                .force_weight  (fweight_reg),
                .res           (fluid[k])
            );
            assign fswap[k] = side0.f[SWAP_DIR[k]];
        end
    endgenerate

    assign tail_next = '{fswap: fswap, rho: side0.rho, u: u0, v: v0, solid: side0.solid};

    always_ff @(posedge clk)
    begin
        tail_reg[0] <= tail_next;
        for (int i = 1; i < DirLat; i++)
            tail_reg[i] <= tail_reg[i-1];
        if (tail_reg[DirLat-1].solid)
            result_reg <= pack_result(tail_reg[DirLat-1].fswap, '0, '0, '0);
        else
            result_reg <= pack_result(fluid, tail_reg[DirLat-1].rho,
                                      tail_reg[DirLat-1].u, tail_reg[DirLat-1].v);
    end

    assign result       = result_reg;
    assign result_valid = vld_reg[Total-1];

endmodule

[bench/lbm_collision_checker.sv]
// Checker for the D2Q9 collision block: predicts each cell's result and compares it.
`timescale 1ns / 100ps

module lbm_collision_checker
    import lbmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  item_t      item,
    input  logic       result_valid,
    input  result_t    result,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  data_t      cfg_data,
    output int         errors,
    output int         pending
);

    typedef logic signed [127:0] acc_t;
    typedef logic [11:0][DATA_WIDTH-1:0] words_t;

    localparam int EX [9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    localparam int EY [9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    localparam int MIRROR [9] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
    localparam acc_t TOP = (acc_t'(1) <<< (DATA_WIDTH - 1)) - 1;
    localparam acc_t BOTTOM = -(acc_t'(1) <<< (DATA_WIDTH - 1));
    localparam acc_t UNIT = acc_t'(1) <<< FRAC_BITS;

    coef_t inv_tau;
    coef_t src_weight;
    data_t accel_x;
    result_t expected_cells[$];
    string field_names [12] = '{"out_rest", "out_east", "out_north", "out_west", "out_south",
        "out_northeast", "out_northwest", "out_southwest", "out_southeast",
        "density", "vel_x", "vel_y"};

    function automatic data_t clip(acc_t x);
        if (x > TOP)
            return data_t'(TOP);
        if (x < BOTTOM)
            return data_t'(BOTTOM);
        return data_t'(x);
    endfunction

    function automatic data_t plus(data_t a, data_t b);
        return clip(acc_t'(a) + acc_t'(b));
    endfunction

    function automatic data_t minus(data_t a, data_t b);
        return clip(acc_t'(a) - acc_t'(b));
    endfunction

    function automatic data_t along(int e, data_t a);
        if (e > 0)
            return a;
        if (e < 0)
            return minus('0, a);
        return '0;
    endfunction

    // Magnitude product, shifted right with rounding half away from zero, then saturated.
    function automatic data_t rmul(data_t a, acc_t b, int sh);
        logic neg;
        acc_t ma;
        acc_t mb;
        acc_t m;
        acc_t lim;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -acc_t'(a) : acc_t'(a);
        mb = (b < 0) ? -b : b;
        m = ma * mb;
        if (sh > 0)
            m = (m + (acc_t'(1) <<< (sh - 1))) >>> sh;
        lim = neg ? TOP + 1 : TOP;
        if (m > lim)
            m = lim;
        return neg ? data_t'(-m) : data_t'(m);
    endfunction

    function automatic data_t qmul(data_t a, data_t b);
        return rmul(a, acc_t'(b), FRAC_BITS);
    endfunction

    function automatic data_t kmul(data_t a, coef_t c);
        return rmul(a, acc_t'({1'b0, c}), COEF_SHIFT);
    endfunction

    function automatic data_t qdiv(data_t n, data_t d);
        logic neg;
        acc_t un;
        acc_t ud;
        acc_t q;
        acc_t r;
        neg = n < 0;
        un = ((n < 0) ? -acc_t'(n) : acc_t'(n)) <<< FRAC_BITS;
        ud = acc_t'(d);
        q = un / ud;
        r = un - q * ud;
        if (r >= ud - r)
            q = q + 1;
        if (q > (neg ? TOP + 1 : TOP))
            q = neg ? TOP + 1 : TOP;
        return neg ? data_t'(-q) : data_t'(q);
    endfunction

    function automatic result_t collide_cell(item_t it);
        data_t f [9];
        data_t o [12];
        data_t w [9];
        data_t one;
        data_t rho;
        data_t mx;
        data_t my;
        data_t fx;
        data_t fy;
        data_t u;
        data_t v;
        data_t uu;
        data_t eu;
        data_t poly;
        data_t feq;
        data_t t1;
        data_t ef;
        data_t s;
        data_t src;
        result_t r;
        f = '{it.f_rest, it.f_east, it.f_north, it.f_west, it.f_south,
              it.f_northeast, it.f_northwest, it.f_southwest, it.f_southeast};
        one = clip(UNIT);
        w[0] = clip(((acc_t'(4) <<< FRAC_BITS) + 4) / 9);
        for (int k = 1; k < 5; k++)
            w[k] = clip((UNIT + 4) / 9);
        for (int k = 5; k < 9; k++)
            w[k] = clip((UNIT + 18) / 36);
        if (it.is_solid) begin
            for (int k = 0; k < 9; k++)
                o[k] = f[MIRROR[k]];
            o[9] = '0;
            o[10] = '0;
            o[11] = '0;
        end else begin
            rho = '0;
            mx = '0;
            my = '0;
            for (int k = 0; k < 9; k++) begin
                rho = plus(rho, f[k]);
                mx = plus(mx, along(EX[k], f[k]));
                my = plus(my, along(EY[k], f[k]));
            end
            // The density floor rounds to one LSB at this fraction width.
            if (rho < data_t'(1))
                rho = data_t'(1);
            fx = plus(it.force_x, accel_x);
            fy = it.force_y;
            u = qdiv(plus(mx, rmul(fx, 1, 1)), rho);
            v = qdiv(plus(my, rmul(fy, 1, 1)), rho);
            uu = plus(qmul(u, u), qmul(v, v));
            for (int k = 0; k < 9; k++) begin
                eu = plus(along(EX[k], u), along(EY[k], v));
                poly = plus(one, rmul(eu, 3, 0));
                poly = plus(poly, rmul(qmul(eu, eu), 9, 1));
                poly = minus(poly, rmul(uu, 3, 1));
                feq = qmul(qmul(w[k], rho), poly);
                t1 = plus(qmul(minus(along(EX[k], one), u), fx),
                          qmul(minus(along(EY[k], one), v), fy));
                ef = plus(along(EX[k], fx), along(EY[k], fy));
                s = plus(rmul(t1, 3, 0), rmul(qmul(eu, ef), 9, 0));
                src = kmul(qmul(w[k], s), src_weight);
                o[k] = plus(minus(f[k], kmul(minus(f[k], feq), inv_tau)), src);
            end
            o[9] = rho;
            o[10] = u;
            o[11] = v;
        end
        r.out_rest      = o[0];
        r.out_east      = o[1];
        r.out_north     = o[2];
        r.out_west      = o[3];
        r.out_south     = o[4];
        r.out_northeast = o[5];
        r.out_northwest = o[6];
        r.out_southwest = o[7];
        r.out_southeast = o[8];
        r.density       = o[9];
        r.vel_x         = o[10];
        r.vel_y         = o[11];
        return r;
    endfunction

    assign pending = expected_cells.size();

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            inv_tau <= coef_t'(81920);
            src_weight <= coef_t'(24576);
            accel_x <= data_t'(26146);
            errors <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RELAX_INV_TAU: inv_tau <= cfg_data[COEF_BITS-1:0];
                    CFG_FORCE_WEIGHT:  src_weight <= cfg_data[COEF_BITS-1:0];
                    CFG_BODY_ACCEL:    accel_x <= cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_cells = {expected_cells, collide_cell(item)};
            if (result_valid) begin
                if (expected_cells.size() == 0) begin
                    if (errors < 10)
                        $display("ERROR: result with no cell outstanding: %h", result);
                    errors <= errors + 1;
                end else begin
                    words_t want;
                    words_t got;
                    int bad;
                    want = words_t'(expected_cells.pop_front());
                    got = words_t'(result);
                    bad = 0;
                    for (int i = 11; i >= 0; i--) begin
                        if (got[i] !== want[i]) begin
                            if (errors + bad < 10)
                                $display("ERROR: %s expected %h got %h",
                                         field_names[11 - i], want[i], got[i]);
                            bad++;
                        end
                    end
                    errors <= errors + bad;
                end
            end
        end
    end

endmodule

[bench/tb_lbm_d2q9_bgk_collision.sv]
// Top of the collision block testbench: clock, reset, cell and register stimulus, verdict.
`timescale 1ns / 100ps

module tb_lbm_d2q9_bgk_collision;
    import lbmc_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    item_t      item;
    logic       result_valid;
    result_t    result;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    data_t      cfg_data;
    int         errors;
    int         pending;
    bit         no_gaps;

    lbm_d2q9_bgk_collision u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lbm_collision_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic data_t any_word();
        return data_t'({$urandom(), $urandom()});
    endfunction

    function automatic data_t spread(int bits);
        return data_t'($signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
    endfunction

    // A cell near rest density with small random disturbances and forces.
    function automatic item_t near_rest_cell();
        item_t c;
        data_t axis;
        data_t diag;
        axis = data_t'(((48'd1 << FRAC_BITS) + 4) / 9);
        diag = data_t'(((48'd1 << FRAC_BITS) + 18) / 36);
        c.f_rest      = 4 * axis + (spread(30) <<< 7);
        c.f_east      = axis + (spread(30) <<< 6);
        c.f_north     = axis + (spread(30) <<< 6);
        c.f_west      = axis + (spread(30) <<< 6);
        c.f_south     = axis + (spread(30) <<< 6);
        c.f_northeast = diag + (spread(30) <<< 4);
        c.f_northwest = diag + (spread(30) <<< 4);
        c.f_southwest = diag + (spread(30) <<< 4);
        c.f_southeast = diag + (spread(30) <<< 4);
        c.force_x     = spread(30);
        c.force_y     = spread(30);
        c.is_solid    = ($urandom_range(0, 6) == 0);
        return c;
    endfunction

    function automatic item_t noise_cell();
        item_t c;
        c = {any_word(), any_word(), any_word(), any_word(), any_word(), any_word(),
             any_word(), any_word(), any_word(), any_word(), any_word(), 1'b0};
        c.is_solid = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic item_t flat_cell(data_t fv, data_t force_v, logic solid);
        item_t c;
        c = '{fv, fv, fv, fv, fv, fv, fv, fv, fv, force_v, force_v, solid};
        return c;
    endfunction

    task automatic send_cell(item_t c);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= c;
        do @(posedge clk); while (busy);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    // Each write drops cfg_valid again and leaves the configuration channel idle before returning.
    task automatic write_reg(logic [1:0] idx, data_t value);
        cfg_valid <= 1'b1;
        cfg_index <= cfg_index_t'(idx);
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(int count);
        int hold_at;
        hold_at = $urandom_range(10, count - 10);
        for (int n = 0; n < count; n++) begin
            no_gaps = (n >= count / 2) && (n < count / 2 + 15);
            if (n == hold_at)
                wait_idle();
            if ($urandom_range(0, 4) == 0)
                send_cell(noise_cell());
            else
                send_cell(near_rest_cell());
        end
        no_gaps = 1'b0;
        wait_idle();
    endtask

    initial begin
        item_t c;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RELAX_INV_TAU;
        cfg_data = '0;
        no_gaps = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cells under the reset coefficients.
        send_cell(flat_cell('0, '0, 1'b0));
        send_cell(flat_cell(DMAX, DMAX, 1'b0));
        send_cell(flat_cell(DMIN, DMIN, 1'b0));
        send_cell(flat_cell(DMAX, DMIN, 1'b0));
        send_cell(flat_cell(DMIN, DMAX, 1'b1));
        send_cell(flat_cell(data_t'(-1), data_t'(1), 1'b0));
        send_cell(flat_cell(data_t'(1), '0, 1'b0));
        c = near_rest_cell();
        c.is_solid = 1'b1;
        send_cell(c);
        c = noise_cell();
        c.is_solid = 1'b1;
        send_cell(c);
        for (int n = 0; n < 6; n++) begin
            c = near_rest_cell();
            c.is_solid = 1'b0;
            send_cell(c);
        end
        // Negative density, zero density with a force, and saturated momentum.
        c = near_rest_cell();
        c.is_solid = 1'b0;
        c.f_rest = data_t'(-(48'sd1 <<< 44));
        send_cell(c);
        c = flat_cell('0, DMAX, 1'b0);
        send_cell(c);
        c = flat_cell('0, '0, 1'b0);
        c.f_east = DMAX;
        c.f_northeast = DMAX;
        c.f_southeast = DMAX;
        send_cell(c);
        c = flat_cell('0, '0, 1'b0);
        c.f_west = DMAX;
        c.f_south = DMAX;
        c.force_x = DMIN;
        send_cell(c);
        wait_idle();

        random_phase(70);

        write_reg(CFG_RELAX_INV_TAU, '0);
        write_reg(CFG_FORCE_WEIGHT, '0);
        write_reg(CFG_BODY_ACCEL, DMIN);
        random_phase(50);

        write_reg(CFG_RELAX_INV_TAU, DMAX);
        write_reg(CFG_FORCE_WEIGHT, data_t'({30'h3abc_def1, 18'h3ffff}));
        write_reg(CFG_BODY_ACCEL, DMAX);
        random_phase(50);

        // An unknown index must leave every register alone.
        write_reg(CFG_UNUSED, any_word());
        write_reg(CFG_RELAX_INV_TAU, data_t'(106496));
        write_reg(CFG_FORCE_WEIGHT, data_t'(11469));
        write_reg(CFG_BODY_ACCEL, spread(24));
        random_phase(90);

        for (int p = 0; p < 3; p++) begin
            write_reg(CFG_RELAX_INV_TAU, any_word());
            write_reg(CFG_FORCE_WEIGHT, any_word());
            write_reg(CFG_BODY_ACCEL, ($urandom_range(0, 1) != 0) ? any_word() : spread(28));
            random_phase(50);
        end

        wait_idle();
        repeat (80) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[lbm_d2q9_bgk_collision.f]
design/lbmc_pkg.sv
design/lbmc_mul.sv
design/lbmc_div.sv
design/lbmc_dir.sv
design/lbm_d2q9_bgk_collision.sv
bench/lbm_collision_checker.sv
bench/tb_lbm_d2q9_bgk_collision.sv
